### hdl/pllc_pkg.sv
// Package for the password lock command controller.
// Holds the beat types, command and reply codes, and register reset values.
// No dependencies.
package pllc_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgAlarmSeconds   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDoorMoveSeconds = 1'b1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [7:0] AlarmSecondsRst   = 8'd60;
  localparam logic [7:0] DoorMoveSecondsRst = 8'd15;

  // Command bytes received from the host.
  localparam logic [7:0] CmdGetStatus     = 8'hE1;
  localparam logic [7:0] CmdSetNewPass    = 8'hE2;
  localparam logic [7:0] CmdConfirmPass   = 8'hE4;
  localparam logic [7:0] CmdCheckPass     = 8'hE7;
  localparam logic [7:0] CmdAttemptsEnded = 8'hF0;
  localparam logic [7:0] CmdUnlockDoor    = 8'hF1;

  // Reply bytes sent back to the host.
  localparam logic [7:0] RspNextDigit = 8'hE3;
  localparam logic [7:0] RspMatch     = 8'hE5;
  localparam logic [7:0] RspNoMatch   = 8'hE6;
  localparam logic [7:0] RspLockDoor  = 8'hF2;

  // Tag that marks a stored password as valid, and the erased store value.
  localparam logic [7:0] TagValid  = 8'h23;
  localparam logic [7:0] ErasedVal = 8'hFF;

  // Motor drive codes.
  localparam logic [1:0] MotorStop  = 2'd0;
  localparam logic [1:0] MotorOpen  = 2'd1;
  localparam logic [1:0] MotorClose = 2'd2;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic       motion;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       buzz_on;
    logic [1:0] motor_dir;
  } result_t;

endpackage

### hdl/pllc_if.sv
// Valid/ready channel interfaces for the password lock command controller.
// The input channel carries command bytes and ticks, the output channel carries results.
// No dependencies.
interface pllc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;
  logic       motion;

  modport source (output valid, func, rx_byte, motion, input ready);
  modport sink (input valid, func, rx_byte, motion, output ready);
endinterface

interface pllc_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       buzz_on;
  logic [1:0] motor_dir;

  modport source (output valid, tx_valid, tx_byte, buzz_on, motor_dir, input ready);
  modport sink (input valid, tx_valid, tx_byte, buzz_on, motor_dir, output ready);
endinterface

### hdl/pllc_core.sv
// Command state machine with the password entry, stored and active password registers.
// Processes one registered beat per step and returns its result combinationally.
// Depends on pllc_pkg.
module pllc_core #(
  parameter int unsigned DIGITS = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  pllc_pkg::item_t item_i,
  input  logic [7:0]      alarm_seconds_i,
  input  logic [7:0]      door_move_seconds_i,
  output pllc_pkg::result_t result_o
);
  import pllc_pkg::*;

  localparam int unsigned CntW = $clog2(DIGITS + 1);
  localparam int unsigned IdxW = $clog2(DIGITS);
  localparam logic [CntW-1:0] DigitsC = CntW'(DIGITS);

  // Phase codes.
  localparam logic [3:0] PhIdle     = 4'd0;
  localparam logic [3:0] PhNew      = 4'd1;
  localparam logic [3:0] PhWaitConf = 4'd2;
  localparam logic [3:0] PhConf     = 4'd3;
  localparam logic [3:0] PhCheck    = 4'd4;
  localparam logic [3:0] PhAlarm    = 4'd5;
  localparam logic [3:0] PhOpen     = 4'd6;
  localparam logic [3:0] PhClear    = 4'd7;
  localparam logic [3:0] PhClose    = 4'd8;

  logic [3:0]      phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      ticks_q, ticks_d;

  logic [7:0] first_q  [DIGITS];
  logic [7:0] second_q [DIGITS];
  logic [7:0] stored_q [DIGITS];
  logic [7:0] active_q [DIGITS];
  logic [7:0] first_tag_q;
  logic [7:0] stored_tag_q;

  logic first_we, first_tag_we, second_we, store_we, load_active;
  logic eq_first_second, eq_second_active, ok;
  logic [IdxW-1:0] wr_idx;

  assign wr_idx = cnt_q[IdxW-1:0];

  // Digit compares are independent per position.
  always_comb begin
    eq_first_second  = 1'b1;
    eq_second_active = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      if (first_q[i] != second_q[i]) eq_first_second = 1'b0;
      if (second_q[i] != active_q[i]) eq_second_active = 1'b0;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    ticks_d      = ticks_q;
    first_we     = 1'b0;
    first_tag_we = 1'b0;
    second_we    = 1'b0;
    store_we     = 1'b0;
    load_active  = 1'b0;
    ok           = 1'b0;
    result_o     = '0;

    unique case (phase_q)
      PhIdle: begin
        if (!item_i.func) begin
          unique case (item_i.rx_byte)
            CmdGetStatus: begin
              result_o.tx_valid = 1'b1;
              result_o.tx_byte  = stored_tag_q;
              load_active       = (stored_tag_q == TagValid);
            end
            CmdSetNewPass: begin
              phase_d = PhNew;
              cnt_d   = '0;
            end
            CmdCheckPass: begin
              phase_d = PhCheck;
              cnt_d   = '0;
            end
            CmdAttemptsEnded: begin
              ticks_d = alarm_seconds_i;
              phase_d = (alarm_seconds_i == 8'd0) ? PhIdle : PhAlarm;
            end
            CmdUnlockDoor: begin
              ticks_d = door_move_seconds_i;
              phase_d = (door_move_seconds_i == 8'd0) ? PhClear : PhOpen;
            end
            default: begin
            end
          endcase
        end
      end
      PhNew, PhConf, PhCheck: begin
        if (!item_i.func) begin
          if (cnt_q < DigitsC) begin
            first_we          = (phase_q == PhNew);
            second_we         = (phase_q != PhNew);
            cnt_d             = cnt_q + 1'b1;
            result_o.tx_valid = 1'b1;
            result_o.tx_byte  = RspNextDigit;
          end else if (phase_q == PhNew) begin
            first_tag_we = 1'b1;
            cnt_d        = '0;
            phase_d      = PhWaitConf;
          end else begin
            ok = (phase_q == PhConf) ? eq_first_second : eq_second_active;
            result_o.tx_valid = 1'b1;
            result_o.tx_byte  = ok ? RspMatch : RspNoMatch;
            store_we = ok && (phase_q == PhConf);
            cnt_d    = '0;
            phase_d  = PhIdle;
          end
        end
      end
      PhWaitConf: begin
        if (!item_i.func && item_i.rx_byte == CmdConfirmPass) begin
          cnt_d   = '0;
          phase_d = PhConf;
        end
      end
      PhAlarm, PhOpen, PhClose: begin
        if (item_i.func) begin
          if (ticks_q <= 8'd1) begin
            ticks_d = 8'd0;
            phase_d = (phase_q == PhOpen) ? PhClear : PhIdle;
          end else begin
            ticks_d = ticks_q - 8'd1;
          end
        end
      end
      PhClear: begin
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase

    // Once the door is open and the doorway is clear, close it on this beat.
    if (phase_d == PhClear && !item_i.motion) begin
      result_o.tx_valid = 1'b1;
      result_o.tx_byte  = RspLockDoor;
      ticks_d = door_move_seconds_i;
      phase_d = (door_move_seconds_i == 8'd0) ? PhIdle : PhClose;
    end

    result_o.buzz_on   = (phase_d == PhAlarm);
    result_o.motor_dir = (phase_d == PhOpen)  ? MotorOpen :
                         (phase_d == PhClose) ? MotorClose : MotorStop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q   <= '0;
      ticks_q <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      ticks_q <= ticks_d;
    end
  end

  // Entry registers are always written before they are read.
  always_ff @(posedge clk_i) begin
    if (step_i && first_we) first_q[wr_idx] <= item_i.rx_byte;
    if (step_i && second_we) second_q[wr_idx] <= item_i.rx_byte;
    if (step_i && first_tag_we) first_tag_q <= item_i.rx_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGITS; i++) begin
        stored_q[i] <= ErasedVal;
        active_q[i] <= 8'd0;
      end
      stored_tag_q <= ErasedVal;
    end else if (step_i) begin
      if (store_we) begin
        for (int i = 0; i < DIGITS; i++) begin
          stored_q[i] <= first_q[i];
          active_q[i] <= first_q[i];
        end
        stored_tag_q <= first_tag_q;
      end else if (load_active) begin
        for (int i = 0; i < DIGITS; i++) active_q[i] <= stored_q[i];
      end
    end
  end

endmodule

### hdl/password_lock_command_controller_unit.sv
// Top level of the password lock command controller: input register, configuration
// registers, the command core and the result register.
// Depends on pllc_pkg, pllc_if.sv and pllc_core.
//
// The controller takes one beat per cycle on item_i while result_o is not stalled:
// either a received serial command byte (func = 0) or a one-second tick (func = 1),
// with the motion sensor level sampled on every beat. Every accepted beat yields
// exactly one result beat on result_o with the reply byte (when tx_valid is set), the
// buzzer level and the motor drive. The path is an input register followed by a
// result register, and a new beat is taken every cycle while result_o is not stalled.
// When result_o is stalled the result register holds its beat, and the input
// register then holds back item_i once it holds a beat. The password store is
// held in flip-flops and is erased (all 0xFF) by reset, so no clearing pass is needed.
// The alarm and door timing registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
// and should only be written while no beat is in flight.
module password_lock_command_controller_unit #(
  parameter int unsigned DIGITS = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pllc_in_if.sink                       item_i,
  pllc_out_if.source                    result_o,
  input  logic                          cfg_we_i,
  input  logic [pllc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pllc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import pllc_pkg::*;

  logic [7:0] alarm_seconds_q;
  logic [7:0] door_move_seconds_q;

  logic    in_vld_q;
  item_t   in_q;
  logic    out_vld_q;
  result_t out_q;
  result_t core_res;
  logic    step;

  // The core advances when a beat is held and the result register is free or draining.
  assign step         = in_vld_q && (!out_vld_q || result_o.ready);
  assign item_i.ready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_seconds_q     <= AlarmSecondsRst;
      door_move_seconds_q <= DoorMoveSecondsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAlarmSeconds:    alarm_seconds_q     <= cfg_wdata_i;
        CfgDoorMoveSeconds: door_move_seconds_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (item_i.ready) begin
      in_vld_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      in_q.func    <= item_i.func;
      in_q.rx_byte <= item_i.rx_byte;
      in_q.motion  <= item_i.motion;
    end
  end

  pllc_core #(
    .DIGITS(DIGITS)
  ) u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (step),
    .item_i             (in_q),
    .alarm_seconds_i    (alarm_seconds_q),
    .door_move_seconds_i(door_move_seconds_q),
    .result_o           (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_q <= core_res;
  end

  assign result_o.valid     = out_vld_q;
  assign result_o.tx_valid  = out_q.tx_valid;
  assign result_o.tx_byte   = out_q.tx_byte;
  assign result_o.buzz_on   = out_q.buzz_on;
  assign result_o.motor_dir = out_q.motor_dir;

endmodule
